// ===== hw/rtl/bistable_relay_coil_sequencer_macros.svh =====
// Assertion macros for the relay coil sequencer.
// Define NO_ASSERTIONS to compile them away.
`ifndef BISTABLE_RELAY_COIL_SEQUENCER_MACROS_SVH
`define BISTABLE_RELAY_COIL_SEQUENCER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BRCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brcs assertion failed");
`define BRCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brcs assertion failed");
`else
`define BRCS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BRCS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/brcs_pkg.sv =====
// Package for the relay coil sequencer: types, codes and constants.
// No dependencies.
`timescale 1ns / 1ps

package brcs_pkg;

    localparam int unsigned APB_AW = 3;

    localparam logic [7:0] POL_FALSE = 8'hC0;
    localparam logic [7:0] POL_TRUE  = 8'h30;
    localparam logic [7:0] POL_NONE  = 8'h50;

    localparam logic [7:0]  COIL_ON_RESET  = 8'd20;
    localparam logic [15:0] RECHARGE_RESET = 16'd100;

    localparam logic CFG_IDX_COIL_ON  = 1'b0;
    localparam logic CFG_IDX_RECHARGE = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SET    = 2'd1,
        OP_PULSE  = 2'd2,
        OP_TOGGLE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_PULSE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        LVL_UNKNOWN = 2'd0,
        LVL_FALSE   = 2'd1,
        LVL_TRUE    = 2'd2
    } t_lvl;

    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_SET       = 7'b0000010,
        PH_SET_OFF   = 7'b0000100,
        PH_PULSE     = 7'b0001000,
        PH_PULSE_OFF = 7'b0010000,
        PH_REVERSE   = 7'b0100000,
        PH_FINAL_OFF = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0]  coil_on_ticks;
        logic [15:0] recharge_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  operation;
        logic        level;
        logic [23:0] pulse_ticks;
    } t_in_item;

    typedef struct packed {
        logic [7:0] coil_pattern;
        logic [1:0] relay_state;
        logic       busy_res;
    } t_res;

    // zero delay behaves as one tick
    function automatic logic [23:0] f_sched(input logic [23:0] n);
        return (n == 24'd0) ? 24'd1 : n;
    endfunction

endpackage

// ===== hw/rtl/brcs_if.sv =====
// Valid/ready channel interfaces for command input and coil result output.
// No dependencies.
`timescale 1ns / 1ps

interface brcs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic        level;
    logic [23:0] pulse_ticks;

    modport source (output valid, output operation, output level, output pulse_ticks,
                    input ready);
    modport sink   (input valid, input operation, input level, input pulse_ticks,
                    output ready);
endinterface

interface brcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] coil_pattern;
    logic [1:0] relay_state;
    logic       busy_res;

    modport source (output valid, output coil_pattern, output relay_state,
                    output busy_res, input ready);
    modport sink   (input valid, input coil_pattern, input relay_state,
                    input busy_res, output ready);
endinterface

// ===== hw/rtl/bistable_relay_coil_sequencer.sv =====
// Top level of the bistable relay coil sequencer: input and result registers,
// configuration block and sequencer core. Depends on brcs_pkg, brcs_if, brcs_cfg,
// brcs_core and the assertion macros.
// Usage:
//   i_in carries one transaction per tick or command: operation 0 is a tick,
//   1 set level, 2 pulse, 3 toggle, with level and pulse_ticks as payload.
//   o_out returns exactly one transaction per input: coil_pattern, relay_state
//   and busy_res as they stand after that input has been applied.
//   The APB port holds coil_on_ticks at address 0 and recharge_ticks at 4;
//   write them only while no transaction is in flight.
// Timing:
//   An input passes an input register and then lands in the result register.
//   One transaction per cycle sustained while o_out.ready stays high; the rate
//   is set by the single-pass state update in the core.
// Reset:
//   Synchronous active-low reset empties both registers, puts coils off (0x50),
//   relay level unknown, no command pending and registers to 20 and 100.
// Stall:
//   While o_out.ready is low the result is held; one more input is taken into
//   the input register, then i_in.ready drops until the result is taken.
`timescale 1ns / 1ps
`include "bistable_relay_coil_sequencer_macros.svh"

module bistable_relay_coil_sequencer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    brcs_in_if.sink                      i_in,
    brcs_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [brcs_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import brcs_pkg::*;

    t_cfg     w_cfg;
    t_res     w_next;
    t_in_item r_in_item;
    logic     r_in_valid;
    t_res     r_out_res;
    logic     r_out_valid;
    logic     w_adv;
    logic     w_fire;
    logic     w_acc;

    brcs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    brcs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in_item),
        .i_cfg   (w_cfg),
        .o_next  (w_next)
    );

    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_fire     = r_in_valid && w_adv;
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_acc      = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_in_item.operation   <= i_in.operation;
            r_in_item.level       <= i_in.level;
            r_in_item.pulse_ticks <= i_in.pulse_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_res <= w_next;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.coil_pattern = r_out_res.coil_pattern;
    assign o_out.relay_state  = r_out_res.relay_state;
    assign o_out.busy_res     = r_out_res.busy_res;

    `BRCS_ASSERT_NXT(a_fire_result, i_clk, i_rst_n, w_fire, r_out_valid)
    `BRCS_ASSERT_NXT(a_acc_loaded, i_clk, i_rst_n, w_acc, r_in_valid)
    `BRCS_ASSERT_IMP(a_no_drop, i_clk, i_rst_n, r_in_valid && !w_adv, !i_in.ready)

endmodule

// ===== hw/rtl/brcs_cfg.sv =====
// APB register block: coil-on and recharge tick counts.
// Depends on brcs_pkg.
`timescale 1ns / 1ps

module brcs_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [brcs_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output brcs_pkg::t_cfg               o_cfg
);
    import brcs_pkg::*;

    logic [7:0]  r_coil_on;
    logic [15:0] r_recharge;
    logic        w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coil_on  <= COIL_ON_RESET;
            r_recharge <= RECHARGE_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                CFG_IDX_COIL_ON: begin
                    r_coil_on <= pwdata[7:0];
                end
                CFG_IDX_RECHARGE: begin
                    r_recharge <= pwdata[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            CFG_IDX_COIL_ON:  prdata = {24'd0, r_coil_on};
            CFG_IDX_RECHARGE: prdata = {16'd0, r_recharge};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg.coil_on_ticks  = r_coil_on;
    assign o_cfg.recharge_ticks = r_recharge;

endmodule

// ===== hw/rtl/brcs_core.sv =====
// Sequencer state and its single-pass next-state logic for one transaction.
// Depends on brcs_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "bistable_relay_coil_sequencer_macros.svh"

module brcs_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  brcs_pkg::t_in_item i_item,
    input  brcs_pkg::t_cfg     i_cfg,
    output brcs_pkg::t_res     o_next
);
    import brcs_pkg::*;

    t_phase      r_phase,    n_phase;
    t_cmd        r_pending,  n_pending;
    logic        r_desired,  n_desired;
    logic [23:0] r_plen,     n_plen;
    t_lvl        r_believed, n_believed;
    logic [23:0] r_wait,     n_wait;
    logic        r_active,   n_active;
    logic [7:0]  r_drive,    n_drive;
    logic        w_run;
    t_phase      w_phase;
    t_lvl        w_rev;

    always_comb begin
        n_phase    = r_phase;
        n_pending  = r_pending;
        n_desired  = r_desired;
        n_plen     = r_plen;
        n_believed = r_believed;
        n_wait     = r_wait;
        n_active   = r_active;
        n_drive    = r_drive;
        w_run      = 1'b0;
        w_phase    = r_phase;
        w_rev      = (r_believed == LVL_TRUE) ? LVL_FALSE : LVL_TRUE;

        if (i_fire) begin
            case (t_op'(i_item.operation))
                OP_TICK: begin
                    if (r_active) begin
                        if (r_wait > 24'd1) begin
                            n_wait = r_wait - 24'd1;
                        end else begin
                            w_run = 1'b1;
                        end
                    end
                end
                OP_SET: begin
                    n_pending = CMD_SET;
                    n_desired = i_item.level;
                    if (!r_active) begin
                        n_active = 1'b1;
                        n_wait   = 24'd1;
                    end
                end
                OP_PULSE: begin
                    n_pending = CMD_PULSE;
                    n_desired = i_item.level;
                    n_plen    = i_item.pulse_ticks;
                    if (!r_active) begin
                        n_active = 1'b1;
                        n_wait   = 24'd1;
                    end
                end
                OP_TOGGLE: begin
                    if (r_believed == LVL_FALSE || r_believed == LVL_TRUE) begin
                        n_pending = CMD_SET;
                        n_desired = (r_believed == LVL_FALSE);
                        if (!r_active) begin
                            n_active = 1'b1;
                            n_wait   = 24'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (w_run) begin
            if (r_phase == PH_IDLE) begin
                if (r_pending == CMD_SET) begin
                    n_pending = CMD_NONE;
                    w_phase   = PH_SET;
                end else if (r_pending == CMD_PULSE) begin
                    n_pending = CMD_NONE;
                    w_phase   = PH_PULSE;
                end else begin
                    n_active = 1'b0;
                    n_wait   = 24'd0;
                end
            end
            case (w_phase)
                PH_IDLE: begin
                end
                PH_SET, PH_PULSE: begin
                    n_believed = r_desired ? LVL_TRUE : LVL_FALSE;
                    n_drive    = r_desired ? POL_TRUE : POL_FALSE;
                    n_phase    = (w_phase == PH_SET) ? PH_SET_OFF : PH_PULSE_OFF;
                    n_wait     = f_sched({16'd0, i_cfg.coil_on_ticks});
                end
                PH_SET_OFF, PH_FINAL_OFF: begin
                    n_drive = POL_NONE;
                    n_phase = PH_IDLE;
                    n_wait  = f_sched({8'd0, i_cfg.recharge_ticks});
                end
                PH_PULSE_OFF: begin
                    n_drive = POL_NONE;
                    n_phase = PH_REVERSE;
                    n_wait  = f_sched(r_plen);
                end
                PH_REVERSE: begin
                    n_believed = w_rev;
                    n_drive    = (w_rev == LVL_TRUE) ? POL_TRUE : POL_FALSE;
                    n_phase    = PH_FINAL_OFF;
                    n_wait     = f_sched({16'd0, i_cfg.coil_on_ticks});
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_wait  = 24'd1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_pending  <= CMD_NONE;
            r_desired  <= 1'b0;
            r_plen     <= 24'd0;
            r_believed <= LVL_UNKNOWN;
            r_wait     <= 24'd0;
            r_active   <= 1'b0;
            r_drive    <= POL_NONE;
        end else begin
            r_phase    <= n_phase;
            r_pending  <= n_pending;
            r_desired  <= n_desired;
            r_plen     <= n_plen;
            r_believed <= n_believed;
            r_wait     <= n_wait;
            r_active   <= n_active;
            r_drive    <= n_drive;
        end
    end

    assign o_next.coil_pattern = n_drive;
    assign o_next.relay_state  = n_believed;
    assign o_next.busy_res     = n_active;

    // wait counter is nonzero exactly while the task runs
    `BRCS_ASSERT_IMP(a_wait_active, i_clk, i_rst_n, 1'b1, (r_wait != 24'd0) == r_active)
    `BRCS_ASSERT_IMP(a_phase_active, i_clk, i_rst_n, r_phase != PH_IDLE, r_active)
    `BRCS_ASSERT_IMP(a_drive_legal, i_clk, i_rst_n, 1'b1,
        r_drive == POL_NONE || r_drive == POL_TRUE || r_drive == POL_FALSE)
    // energized coil implies a known level
    `BRCS_ASSERT_IMP(a_drive_known, i_clk, i_rst_n, r_drive != POL_NONE,
        r_believed != LVL_UNKNOWN)

endmodule

// ===== dv/tb_bistable_relay_coil_sequencer.sv =====
// Testbench for bistable_relay_coil_sequencer: directed and random command/tick streams,
// APB register setup between phases, scoreboard with its own coil sequence predictor.
// Depends on brcs_pkg, brcs_if and the RTL top level.
`timescale 1ns / 1ps

module tb_bistable_relay_coil_sequencer;
    import brcs_pkg::*;

    class relay_seq_scoreboard;
        bit [7:0]    coil_on;
        bit [15:0]   recharge;
        t_phase      phase;
        t_cmd        pend;
        bit          want_true;
        bit [23:0]   pulse_len;
        t_lvl        belief;
        bit [23:0]   wait_cnt;
        bit          active;
        bit [7:0]    drive;
        t_res        coil_q[$];
        int          errors;

        function new();
            coil_on   = COIL_ON_RESET;
            recharge  = RECHARGE_RESET;
            phase     = PH_IDLE;
            pend      = CMD_NONE;
            want_true = 1'b0;
            pulse_len = '0;
            belief    = LVL_UNKNOWN;
            wait_cnt  = '0;
            active    = 1'b0;
            drive     = POL_NONE;
            errors    = 0;
        endfunction

        function int pending();
            return coil_q.size();
        endfunction

        function void hold_for(bit [23:0] n);
            wait_cnt = (n == 24'd0) ? 24'd1 : n;
        endfunction

        function void energize();
            drive = (belief == LVL_TRUE) ? POL_TRUE : POL_FALSE;
        endfunction

        function void wake();
            if (!active) begin
                active   = 1'b1;
                wait_cnt = 24'd1;
            end
        endfunction

        function void advance_sequence();
            if (phase == PH_IDLE) begin
                if (pend == CMD_SET) begin
                    pend  = CMD_NONE;
                    phase = PH_SET;
                end else if (pend == CMD_PULSE) begin
                    pend  = CMD_NONE;
                    phase = PH_PULSE;
                end else begin
                    active   = 1'b0;
                    wait_cnt = '0;
                    return;
                end
            end
            case (phase)
                PH_SET, PH_PULSE: begin
                    belief = want_true ? LVL_TRUE : LVL_FALSE;
                    energize();
                    phase = (phase == PH_SET) ? PH_SET_OFF : PH_PULSE_OFF;
                    hold_for({16'd0, coil_on});
                end
                PH_SET_OFF, PH_FINAL_OFF: begin
                    drive = POL_NONE;
                    phase = PH_IDLE;
                    hold_for({8'd0, recharge});
                end
                PH_PULSE_OFF: begin
                    drive = POL_NONE;
                    phase = PH_REVERSE;
                    hold_for(pulse_len);
                end
                PH_REVERSE: begin
                    belief = (belief == LVL_TRUE) ? LVL_FALSE : LVL_TRUE;
                    energize();
                    phase = PH_FINAL_OFF;
                    hold_for({16'd0, coil_on});
                end
                default: begin
                    phase = PH_IDLE;
                    hold_for(24'd1);
                end
            endcase
        endfunction

        function void note_input(t_in_item it);
            t_res r;
            case (it.operation)
                OP_TICK: begin
                    if (active) begin
                        if (wait_cnt > 24'd1)
                            wait_cnt = wait_cnt - 24'd1;
                        else
                            advance_sequence();
                    end
                end
                OP_SET: begin
                    pend      = CMD_SET;
                    want_true = it.level;
                    wake();
                end
                OP_PULSE: begin
                    pend      = CMD_PULSE;
                    pulse_len = it.pulse_ticks;
                    want_true = it.level;
                    wake();
                end
                default: begin
                    if (belief == LVL_FALSE || belief == LVL_TRUE) begin
                        pend      = CMD_SET;
                        want_true = (belief == LVL_FALSE);
                        wake();
                    end
                end
            endcase
            r.coil_pattern = drive;
            r.relay_state  = belief;
            r.busy_res     = active;
            coil_q.push_back(r);
        endfunction

        function void report(string what, int exp_v, int act_v);
            errors++;
            if (errors <= 10)
                $display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $realtime, what,
                         exp_v, act_v);
        endfunction

        function void check_result(t_res got);
            t_res exp_r;
            if (coil_q.size() == 0) begin
                report("unexpected transaction, coil_pattern", 0, int'(got.coil_pattern));
                return;
            end
            exp_r = coil_q.pop_front();
            if (got.coil_pattern !== exp_r.coil_pattern)
                report("coil_pattern", int'(exp_r.coil_pattern), int'(got.coil_pattern));
            if (got.relay_state !== exp_r.relay_state)
                report("relay_state", int'(exp_r.relay_state), int'(got.relay_state));
            if (got.busy_res !== exp_r.busy_res)
                report("busy_res", int'(exp_r.busy_res), int'(got.busy_res));
        endfunction
    endclass

    localparam int STALL_LIMIT = 2000;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    brcs_in_if  in_ch ();
    brcs_out_if out_ch ();

    relay_seq_scoreboard sb;
    int unsigned         src_idle_pct;
    int unsigned         snk_stall_pct;
    int                  quiet_cycles;

    bistable_relay_coil_sequencer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // input transaction is noted before the result check of the same edge
    always @(posedge i_clk) begin
        t_in_item it;
        t_res     got;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            it.operation   = in_ch.operation;
            it.level       = in_ch.level;
            it.pulse_ticks = in_ch.pulse_ticks;
            sb.note_input(it);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.coil_pattern = out_ch.coil_pattern;
            got.relay_state  = out_ch.relay_state;
            got.busy_res     = out_ch.busy_res;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel
                || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("bistable_relay_coil_sequencer regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_item mk(t_op op, bit lvl, bit [23:0] len);
        t_in_item it;
        it.operation   = op;
        it.level       = lvl;
        it.pulse_ticks = len;
        return it;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item    it;
        int unsigned r;
        r              = $urandom_range(0, 99);
        it.level       = 1'($urandom_range(0, 1));
        it.pulse_ticks = 24'($urandom());
        if (r < 70)
            it.operation = OP_TICK;
        else if (r < 82)
            it.operation = OP_SET;
        else if (r < 92)
            it.operation = OP_PULSE;
        else
            it.operation = OP_TOGGLE;
        if (it.operation == OP_PULSE && $urandom_range(0, 99) < 85)
            it.pulse_ticks = 24'($urandom_range(0, 6));
        return it;
    endfunction

    task automatic send(input t_in_item it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= it.operation;
        in_ch.level       <= it.level;
        in_ch.pulse_ticks <= it.pulse_ticks;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // advance the clock first so the last accepted transaction is already queued
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input bit [7:0] con, input bit [15:0] rech);
        drain();
        apb_write({CFG_IDX_COIL_ON, 2'b00}, {24'd0, con});
        apb_write({CFG_IDX_RECHARGE, 2'b00}, {16'd0, rech});
        sb.coil_on  = con;
        sb.recharge = rech;
    endtask

    // large pulse lengths are always overridden before they can be taken up
    task automatic run_random(input int n_items);
        t_in_item it;
        for (int i = 0; i < n_items; i++) begin
            it = rand_item();
            send(it);
            if (it.operation == OP_PULSE && it.pulse_ticks > 24'd6)
                send(mk(OP_PULSE, 1'($urandom_range(0, 1)), 24'($urandom_range(0, 6))));
            if (i % 100 == 99)
                drain();
        end
    endtask

    initial begin
        sb                = new();
        src_idle_pct      = 0;
        snk_stall_pct     = 0;
        quiet_cycles      = 0;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.operation   = OP_TICK;
        in_ch.level       = 1'b0;
        in_ch.pulse_ticks = '0;
        out_ch.ready      = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(8'd0, 16'd0);
        send(mk(OP_TICK, 1'b1, 24'hFFFFFF));
        send(mk(OP_TOGGLE, 1'b1, 24'h0));
        send(mk(OP_SET, 1'b1, 24'h0));
        repeat (3) send(mk(OP_TICK, 1'b0, 24'h0));
        send(mk(OP_TOGGLE, 1'b0, 24'h0));
        repeat (3) send(mk(OP_TICK, 1'b0, 24'h0));
        send(mk(OP_PULSE, 1'b1, 24'h0));
        repeat (5) send(mk(OP_TICK, 1'b0, 24'h0));
        send(mk(OP_PULSE, 1'b0, 24'hFFFFFF));
        send(mk(OP_SET, 1'b0, 24'h0));
        send(mk(OP_SET, 1'b1, 24'h0));
        repeat (2) send(mk(OP_TICK, 1'b0, 24'h0));
        send(mk(OP_TOGGLE, 1'b0, 24'h0));
        repeat (3) send(mk(OP_TICK, 1'b0, 24'h0));

        configure(8'd1, 16'd2);
        run_random(260);

        src_idle_pct = 53;
        configure(8'd3, 16'd0);
        run_random(260);

        src_idle_pct  = 0;
        snk_stall_pct = 53;
        configure(8'd0, 16'd5);
        run_random(260);

        src_idle_pct  = 22;
        snk_stall_pct = 22;
        configure(8'd2, 16'd1);
        run_random(260);

        src_idle_pct  = 0;
        snk_stall_pct = 0;
        configure(8'd255, 16'd65535);
        send(mk(OP_SET, 1'b1, 24'h0));
        repeat (257) send(mk(OP_TICK, 1'b0, 24'h0));
        run_random(40);

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("bistable_relay_coil_sequencer regression: pass");
        end else begin
            $display("bistable_relay_coil_sequencer regression: fail");
        end
        $finish;
    end

endmodule
